@@ rtl/core/stl_pkg.sv @@
// ----------------------------------------------------------------------------
// stl_pkg
// Shared widths, token kind codes and the token and queue entry types of the
// source token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int POS_BITS      = 32;
    localparam int LEN_BITS      = 16;
    localparam int KEYWORD_CHARS = 6;
    localparam int KW_BITS       = 8 * KEYWORD_CHARS;
    localparam int KIND_BITS     = 5;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR   = $clog2(Q_DEPTH);

    typedef logic [KIND_BITS-1:0] t_kind;

    localparam t_kind K_IDENT     = 5'd0;
    localparam t_kind K_NUMBER    = 5'd1;
    localparam t_kind K_STRING    = 5'd2;
    localparam t_kind K_ASSIGN    = 5'd3;
    localparam t_kind K_NEG       = 5'd4;
    localparam t_kind K_EQUALS    = 5'd5;
    localparam t_kind K_LESS      = 5'd6;
    localparam t_kind K_GREATER   = 5'd7;
    localparam t_kind K_NOTEQ     = 5'd8;
    localparam t_kind K_LESSEQ    = 5'd9;
    localparam t_kind K_GREATEREQ = 5'd10;
    localparam t_kind K_LPAREN    = 5'd11;
    localparam t_kind K_RPAREN    = 5'd12;
    localparam t_kind K_LBRACE    = 5'd13;
    localparam t_kind K_RBRACE    = 5'd14;
    localparam t_kind K_LBRACKET  = 5'd15;
    localparam t_kind K_RBRACKET  = 5'd16;
    localparam t_kind K_COMMA     = 5'd17;
    localparam t_kind K_SEMI      = 5'd18;
    localparam t_kind K_PLUS      = 5'd19;
    localparam t_kind K_MINUS     = 5'd20;
    localparam t_kind K_STAR      = 5'd21;
    localparam t_kind K_SLASH     = 5'd22;
    localparam t_kind K_AT        = 5'd23;
    localparam t_kind K_FUN       = 5'd24;
    localparam t_kind K_I64       = 5'd25;
    localparam t_kind K_IF        = 5'd26;
    localparam t_kind K_WHILE     = 5'd27;
    localparam t_kind K_RETURN    = 5'd28;
    localparam t_kind K_ASM       = 5'd29;
    localparam t_kind K_ERROR     = 5'd30;
    localparam t_kind K_END       = 5'd31;

    typedef struct packed {
        t_kind               kind;
        logic [POS_BITS-1:0] start;
        logic [LEN_BITS-1:0] length;
    } t_token;

    // One queue entry carries every token that a single input item produced.
    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_entry;

endpackage

@@ rtl/core/source_token_lexer.sv @@
// ----------------------------------------------------------------------------
// source_token_lexer
// Streaming lexer: source bytes in, tokens out as kind, start and length.
// ----------------------------------------------------------------------------
// The input channel takes one item per cycle: a source byte, or an end of
// input marker when i_func is high. An item is taken when i_valid is high and
// o_stall is low. The result channel presents one token per cycle with
// o_valid; it is taken when i_stall is low. o_run_last marks the last token
// caused by an input item.
// A token that an item completes is written into the queue and then into
// the output register before it is on the outputs. Items are taken back
// to back at one per cycle while o_stall is low; an item that gives two
// tokens occupies the result channel with both in turn, and a four-entry
// queue between the lexer and the output register absorbs such bursts.
// o_stall rises only while that queue is full, which happens when the
// receiver stalls or two-token items arrive in a long run.
// Synchronous reset returns the lexer to idle at position zero, clears the
// sticky error and empties the queue and output register. An end of input
// item also restarts positions at zero for a new source, but keeps the error.
// ----------------------------------------------------------------------------
module source_token_lexer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_func,
    input  logic [7:0]                      i_char_code,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [stl_pkg::KIND_BITS-1:0]   o_token_kind,
    output logic [stl_pkg::POS_BITS-1:0]    o_token_start,
    output logic [stl_pkg::LEN_BITS-1:0]    o_token_length,
    output logic                            o_run_last
);
    import stl_pkg::*;

    logic   full;
    logic   empty;
    logic   push;
    logic   pop;
    t_entry entry;
    t_entry head;

    assign o_stall = full;

    stl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_full      (full),
        .i_func      (i_func),
        .i_char_code (i_char_code),
        .o_push      (push),
        .o_entry     (entry)
    );

    stl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    stl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_run_last     (o_run_last)
    );

endmodule

@@ rtl/core/stl_front.sv @@
// ----------------------------------------------------------------------------
// stl_front
// Accepts source items, runs the lexer state and packs the tokens each item
// produces into one queue entry.
// ----------------------------------------------------------------------------
module stl_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_full,
    input  logic                 i_func,
    input  logic [7:0]           i_char_code,
    output logic                 o_push,
    output stl_pkg::t_entry      o_entry
);
    import stl_pkg::*;

    typedef enum logic [7:0] {
        M_IDLE  = 8'b0000_0001,
        M_NUM   = 8'b0000_0010,
        M_STR   = 8'b0000_0100,
        M_IDENT = 8'b0000_1000,
        M_EQ    = 8'b0001_0000,
        M_BANG  = 8'b0010_0000,
        M_LT    = 8'b0100_0000,
        M_GT    = 8'b1000_0000
    } t_mode;

    // String literals place their last character lowest, so the keywords are
    // spelled backward to keep the first byte in the low bits.
    localparam logic [KW_BITS-1:0] WORD_I64    = KW_BITS'("46i");
    localparam logic [KW_BITS-1:0] WORD_FUN    = KW_BITS'("nuf");
    localparam logic [KW_BITS-1:0] WORD_ASM    = KW_BITS'("msa");
    localparam logic [KW_BITS-1:0] WORD_RET    = KW_BITS'("nruter");
    localparam logic [KW_BITS-1:0] WORD_IF     = KW_BITS'("fi");
    localparam logic [KW_BITS-1:0] WORD_LOOP   = KW_BITS'("elihw");

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    t_mode               r_mode, n_mode;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [POS_BITS-1:0] r_begin, n_begin;
    logic [LEN_BITS-1:0] r_count, n_count;
    logic [KW_BITS-1:0]  r_kw, n_kw;
    logic                r_err, n_err;

    t_token              tok [2];
    logic [1:0]          cnt;
    logic                accept;
    logic                done;
    logic [7:0]          c;
    logic [LEN_BITS-1:0] count_inc;
    t_kind               punct;

    function automatic t_token mk_tok(t_kind k, logic [POS_BITS-1:0] s,
                                      logic [LEN_BITS-1:0] l);
        t_token t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        return t;
    endfunction

    function automatic logic is_digit(logic [7:0] ch);
        return (ch >= "0") && (ch <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] ch);
        return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    endfunction

    function automatic t_kind punct_kind(logic [7:0] ch);
        t_kind k;
        unique case (ch)
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "[":     k = K_LBRACKET;
            "]":     k = K_RBRACKET;
            ",":     k = K_COMMA;
            ";":     k = K_SEMI;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "@":     k = K_AT;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic t_kind ident_kind(logic [LEN_BITS-1:0] n, logic [KW_BITS-1:0] kw);
        t_kind k;
        k = K_IDENT;
        if (n == LEN_BITS'(3) && kw == WORD_I64) begin
            k = K_I64;
        end else if (n == LEN_BITS'(3) && kw == WORD_FUN) begin
            k = K_FUN;
        end else if (n == LEN_BITS'(3) && kw == WORD_ASM) begin
            k = K_ASM;
        end else if (n == LEN_BITS'(6) && kw == WORD_RET) begin
            k = K_RETURN;
        end else if (n == LEN_BITS'(2) && kw == WORD_IF) begin
            k = K_IF;
        end else if (n == LEN_BITS'(5) && kw == WORD_LOOP) begin
            k = K_WHILE;
        end
        return k;
    endfunction

    assign accept    = i_valid && !i_full;
    assign c         = i_char_code;
    assign count_inc = (r_count == LEN_MAX) ? r_count : r_count + LEN_BITS'(1);
    assign punct     = punct_kind(c);

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_begin = r_begin;
        n_count = r_count;
        n_kw    = r_kw;
        n_err   = r_err;
        tok[0]  = '0;
        tok[1]  = '0;
        cnt     = 2'd0;
        done    = 1'b0;

        if (i_func) begin
            if (r_err) begin
                tok[cnt[0]] = mk_tok(K_ERROR, r_begin, '0);
                cnt = cnt + 2'd1;
            end else if (r_mode == M_STR) begin
                n_err = 1'b1;
                tok[cnt[0]] = mk_tok(K_ERROR, r_begin, r_count);
                cnt = cnt + 2'd1;
            end else if (r_mode == M_NUM) begin
                tok[cnt[0]] = mk_tok(K_NUMBER, r_begin, r_count);
                cnt = cnt + 2'd1;
            end else if (r_mode == M_IDENT) begin
                tok[cnt[0]] = mk_tok(ident_kind(r_count, r_kw), r_begin, r_count);
                cnt = cnt + 2'd1;
            end else if (r_mode != M_IDLE) begin
                tok[cnt[0]] = mk_tok((r_mode == M_EQ)   ? K_ASSIGN :
                                     (r_mode == M_BANG) ? K_NEG    :
                                     (r_mode == M_LT)   ? K_LESS   : K_GREATER,
                                     r_begin, LEN_BITS'(1));
                cnt = cnt + 2'd1;
            end
            tok[cnt[0]] = mk_tok(K_END, r_pos, '0);
            cnt     = cnt + 2'd1;
            n_mode  = M_IDLE;
            n_pos   = '0;
            n_count = '0;
            n_kw    = '0;
        end else begin
            if (r_err) begin
                tok[cnt[0]] = mk_tok(K_ERROR, r_begin, '0);
                cnt = cnt + 2'd1;
            end else begin
                unique case (r_mode) inside
                    M_NUM: begin
                        if (is_digit(c)) begin
                            n_count = count_inc;
                            done    = 1'b1;
                        end
                    end
                    M_IDENT: begin
                        if (is_alpha(c) || is_digit(c) || c == "_") begin
                            for (int i = 0; i < KEYWORD_CHARS; i++) begin
                                if (r_count == LEN_BITS'(i)) begin
                                    n_kw[i*8 +: 8] = c;
                                end
                            end
                            n_count = count_inc;
                            done    = 1'b1;
                        end
                    end
                    M_STR: begin
                        n_count = count_inc;
                        if (c == "\"") begin
                            tok[cnt[0]] = mk_tok(K_STRING, r_begin, count_inc);
                            cnt    = cnt + 2'd1;
                            n_mode = M_IDLE;
                        end
                        done = 1'b1;
                    end
                    M_EQ, M_BANG, M_LT, M_GT: begin
                        if (c == "=") begin
                            tok[cnt[0]] = mk_tok((r_mode == M_EQ)   ? K_EQUALS :
                                                 (r_mode == M_BANG) ? K_NOTEQ  :
                                                 (r_mode == M_LT)   ? K_LESSEQ : K_GREATEREQ,
                                                 r_begin, LEN_BITS'(2));
                            cnt    = cnt + 2'd1;
                            n_mode = M_IDLE;
                            done   = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase

                if (!done) begin
                    if (r_mode == M_NUM) begin
                        tok[cnt[0]] = mk_tok(K_NUMBER, r_begin, r_count);
                        cnt = cnt + 2'd1;
                    end else if (r_mode == M_IDENT) begin
                        tok[cnt[0]] = mk_tok(ident_kind(r_count, r_kw), r_begin, r_count);
                        cnt = cnt + 2'd1;
                    end else if (r_mode != M_IDLE) begin
                        tok[cnt[0]] = mk_tok((r_mode == M_EQ)   ? K_ASSIGN :
                                             (r_mode == M_BANG) ? K_NEG    :
                                             (r_mode == M_LT)   ? K_LESS   : K_GREATER,
                                             r_begin, LEN_BITS'(1));
                        cnt = cnt + 2'd1;
                    end
                    n_mode = M_IDLE;

                    if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
                        n_mode = M_IDLE;
                    end else if (is_digit(c)) begin
                        n_mode  = M_NUM;
                        n_begin = r_pos;
                        n_count = LEN_BITS'(1);
                    end else if (c == "\"") begin
                        n_mode  = M_STR;
                        n_begin = r_pos;
                        n_count = LEN_BITS'(1);
                    end else if (is_alpha(c) || c == "_") begin
                        n_mode  = M_IDENT;
                        n_begin = r_pos;
                        n_count = LEN_BITS'(1);
                        n_kw    = KW_BITS'(c);
                    end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
                        n_mode  = (c == "=") ? M_EQ :
                                  (c == "!") ? M_BANG :
                                  (c == "<") ? M_LT : M_GT;
                        n_begin = r_pos;
                        n_count = LEN_BITS'(1);
                    end else begin
                        if (punct == K_ERROR) begin
                            n_err   = 1'b1;
                            n_begin = r_pos;
                        end
                        tok[cnt[0]] = mk_tok(punct, r_pos, LEN_BITS'(1));
                        cnt = cnt + 2'd1;
                    end
                end
            end
            n_pos = r_pos + POS_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
            r_count <= '0;
            r_kw    <= '0;
            r_err   <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_count <= n_count;
            r_kw    <= n_kw;
            r_err   <= n_err;
        end
    end

    assign o_push       = accept && (cnt != 2'd0);
    assign o_entry.two  = cnt[1];
    assign o_entry.tok0 = tok[0];
    assign o_entry.tok1 = tok[1];

endmodule

@@ rtl/core/stl_queue.sv @@
// ----------------------------------------------------------------------------
// stl_queue
// Short first-in first-out queue of token entries between the lexer front
// and the output back end.
// ----------------------------------------------------------------------------
module stl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stl_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output stl_pkg::t_entry  o_head
);
    import stl_pkg::*;

    t_entry           r_mem [Q_DEPTH];
    logic [Q_PTR-1:0] r_wr;
    logic [Q_PTR-1:0] r_rd;
    logic [Q_PTR:0]   r_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == (Q_PTR+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_PTR'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + (Q_PTR+1)'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - (Q_PTR+1)'(1);
            end
        end
    end

endmodule

@@ rtl/core/stl_back.sv @@
// ----------------------------------------------------------------------------
// stl_back
// Takes queue entries apart into single tokens and drives the registered
// result channel, marking the last token of each input item.
// ----------------------------------------------------------------------------
module stl_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    input  stl_pkg::t_entry                 i_head,
    output logic                            o_pop,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [stl_pkg::KIND_BITS-1:0]   o_token_kind,
    output logic [stl_pkg::POS_BITS-1:0]    o_token_start,
    output logic [stl_pkg::LEN_BITS-1:0]    o_token_length,
    output logic                            o_run_last
);
    import stl_pkg::*;

    logic   r_valid;
    logic   r_half;
    t_token r_tok;
    logic   r_last;
    logic   load;
    logic   first_of_two;

    assign load         = !r_valid || !i_stall;
    assign first_of_two = i_head.two && !r_half;
    assign o_pop        = load && !i_empty && !first_of_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_half <= first_of_two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_tok  <= r_half ? i_head.tok1 : i_head.tok0;
            r_last <= !first_of_two;
        end
    end

    assign o_valid        = r_valid;
    assign o_token_kind   = r_tok.kind;
    assign o_token_start  = r_tok.start;
    assign o_token_length = r_tok.length;
    assign o_run_last     = r_last;

endmodule

@@ dv/source_token_lexer_test.sv @@
// ----------------------------------------------------------------------------
// source_token_lexer_test
// Self-checking testbench for the streaming source token lexer. A short table
// of source bytes opens the run, then random source text built from
// well-formed tokens, and last the sticky error case with the items that
// follow it. Every accepted request is tokenized by a model in the bench, and
// each token the block hands out is compared field by field with the oldest
// token still due.
// ----------------------------------------------------------------------------
module source_token_lexer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 600;

    typedef enum logic [2:0] {
        LX_IDLE, LX_NUM, LX_STR, LX_IDENT, LX_EQ, LX_BANG, LX_LT, LX_GT
    } t_lex_mode;

    typedef struct packed {
        t_token tok;
        logic   last;
    } t_due_tok;

    typedef struct packed {
        logic       fn;
        logic [7:0] ch;
        logic [1:0] n_typed;
        t_token     e0;
        t_token     e1;
    } t_plan_row;

    localparam t_token NO_TOK = '0;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                i_func = 1'b0;
    logic [7:0]          i_char_code = 8'h00;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [KIND_BITS-1:0] o_token_kind;
    logic [POS_BITS-1:0] o_token_start;
    logic [LEN_BITS-1:0] o_token_length;
    logic                o_run_last;

    t_lex_mode           lx_mode;
    logic [POS_BITS-1:0] lx_pos;
    logic [POS_BITS-1:0] lx_begin;
    logic [LEN_BITS-1:0] lx_count;
    logic [KW_BITS-1:0]  lx_kw;
    logic                lx_err;

    t_token      step_toks[$];
    t_due_tok    tokens_due[$];
    int          mismatches = 0;
    int          n_fed = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int unsigned cycle_cnt = 0;

    string KEYWORDS[6] = '{"i64", "fun", "asm", "return", "if", "while"};
    string HEAD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string OP_CHARS = "=!<>";
    string PUNCT_CHARS = "(){}[],;+-*/@";
    string NOISE_CHARS = "aZ_m9q0(){}[],;+-*/@=!<> ";

    t_plan_row dir_plan [24] = '{
        '{1'b0, "(",   2'd1, '{K_LPAREN, 32'd0, 16'd1}, NO_TOK},
        '{1'b0, "i",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "f",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, " ",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "r",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "e",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "t",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "u",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "r",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "n",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "=",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "=",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "!",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "<",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "=",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, "\"",  2'd0, NO_TOK, NO_TOK},
        '{1'b0, 8'h80, 2'd0, NO_TOK, NO_TOK},
        '{1'b0, "\"",  2'd0, NO_TOK, NO_TOK},
        '{1'b0, "7",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, ">",   2'd0, NO_TOK, NO_TOK},
        '{1'b0, ";",   2'd2, '{K_GREATER, 32'd19, 16'd1}, '{K_SEMI, 32'd20, 16'd1}},
        '{1'b0, "_",   2'd0, NO_TOK, NO_TOK},
        '{1'b1, 8'hFF, 2'd2, '{K_IDENT, 32'd21, 16'd1}, '{K_END, 32'd22, 16'd0}},
        '{1'b1, 8'h00, 2'd1, '{K_END, 32'd0, 16'd0}, NO_TOK}
    };

    source_token_lexer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_char_code    (i_char_code),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_run_last     (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [KW_BITS-1:0] kw_pack(string s);
        logic [KW_BITS-1:0] v;
        v = '0;
        for (int k = 0; k < s.len(); k++) v[8*k +: 8] = s[k];
        return v;
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function void put(t_kind k, logic [POS_BITS-1:0] s, int unsigned l);
        t_token t;
        t.kind   = k;
        t.start  = s;
        t.length = LEN_BITS'(l);
        step_toks.insert(step_toks.size(), t);
    endfunction

    function void count_up();
        if (lx_count != '1) lx_count = lx_count + LEN_BITS'(1);
    endfunction

    function t_kind word_kind();
        if (lx_count == 3 && lx_kw == kw_pack("i64")) return K_I64;
        if (lx_count == 3 && lx_kw == kw_pack("fun")) return K_FUN;
        if (lx_count == 3 && lx_kw == kw_pack("asm")) return K_ASM;
        if (lx_count == 6 && lx_kw == kw_pack("return")) return K_RETURN;
        if (lx_count == 2 && lx_kw == kw_pack("if")) return K_IF;
        if (lx_count == 5 && lx_kw == kw_pack("while")) return K_WHILE;
        return K_IDENT;
    endfunction

    function void flush_pending();
        case (lx_mode)
            LX_NUM:   put(K_NUMBER, lx_begin, lx_count);
            LX_IDENT: put(word_kind(), lx_begin, lx_count);
            LX_EQ:    put(K_ASSIGN, lx_begin, 1);
            LX_BANG:  put(K_NEG, lx_begin, 1);
            LX_LT:    put(K_LESS, lx_begin, 1);
            LX_GT:    put(K_GREATER, lx_begin, 1);
            default:  ;
        endcase
        lx_mode = LX_IDLE;
    endfunction

    function void begin_tok(t_lex_mode m, logic [POS_BITS-1:0] p);
        lx_mode = m;
        lx_begin = p;
        lx_count = LEN_BITS'(1);
    endfunction

    function void start_fresh(logic [7:0] c, logic [POS_BITS-1:0] p);
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            return;
        end else if (is_digit(c)) begin
            begin_tok(LX_NUM, p);
        end else if (c == "\"") begin
            begin_tok(LX_STR, p);
        end else if (is_alpha(c) || c == "_") begin
            begin_tok(LX_IDENT, p);
            lx_kw = KW_BITS'(c);
        end else begin
            case (c)
                "=": begin_tok(LX_EQ, p);
                "!": begin_tok(LX_BANG, p);
                "<": begin_tok(LX_LT, p);
                ">": begin_tok(LX_GT, p);
                "(": put(K_LPAREN, p, 1);
                ")": put(K_RPAREN, p, 1);
                "{": put(K_LBRACE, p, 1);
                "}": put(K_RBRACE, p, 1);
                "[": put(K_LBRACKET, p, 1);
                "]": put(K_RBRACKET, p, 1);
                ",": put(K_COMMA, p, 1);
                ";": put(K_SEMI, p, 1);
                "+": put(K_PLUS, p, 1);
                "-": put(K_MINUS, p, 1);
                "*": put(K_STAR, p, 1);
                "/": put(K_SLASH, p, 1);
                "@": put(K_AT, p, 1);
                default: begin
                    lx_err = 1'b1;
                    lx_begin = p;
                    put(K_ERROR, p, 1);
                end
            endcase
        end
    endfunction

    function void tokenize_item(logic fn, logic [7:0] c);
        logic                done;
        logic [POS_BITS-1:0] p;
        step_toks.delete();
        p = lx_pos;
        if (fn) begin
            if (lx_err) begin
                put(K_ERROR, lx_begin, 0);
            end else if (lx_mode == LX_STR) begin
                lx_err = 1'b1;
                put(K_ERROR, lx_begin, lx_count);
            end else begin
                flush_pending();
            end
            put(K_END, p, 0);
            lx_mode = LX_IDLE;
            lx_pos = '0;
            lx_count = '0;
            lx_kw = '0;
        end else begin
            if (lx_err) begin
                put(K_ERROR, lx_begin, 0);
            end else begin
                done = 1'b0;
                case (lx_mode) inside
                    LX_NUM: begin
                        if (is_digit(c)) begin
                            count_up();
                            done = 1'b1;
                        end
                    end
                    LX_IDENT: begin
                        if (is_word(c)) begin
                            if (lx_count < KEYWORD_CHARS) lx_kw[8*lx_count +: 8] = c;
                            count_up();
                            done = 1'b1;
                        end
                    end
                    LX_STR: begin
                        count_up();
                        if (c == "\"") begin
                            put(K_STRING, lx_begin, lx_count);
                            lx_mode = LX_IDLE;
                        end
                        done = 1'b1;
                    end
                    LX_EQ, LX_BANG, LX_LT, LX_GT: begin
                        if (c == "=") begin
                            case (lx_mode)
                                LX_EQ:   put(K_EQUALS, lx_begin, 2);
                                LX_BANG: put(K_NOTEQ, lx_begin, 2);
                                LX_LT:   put(K_LESSEQ, lx_begin, 2);
                                default: put(K_GREATEREQ, lx_begin, 2);
                            endcase
                            lx_mode = LX_IDLE;
                            done = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (!done) begin
                    flush_pending();
                    start_fresh(c, p);
                end
            end
            lx_pos = p + POS_BITS'(1);
        end
    endfunction

    function void file_tokens();
        t_due_tok d;
        for (int k = 0; k < step_toks.size(); k++) begin
            d.tok  = step_toks[k];
            d.last = (k == step_toks.size() - 1);
            tokens_due.insert(tokens_due.size(), d);
        end
    endfunction

    task automatic drive_item(input logic fn, input logic [7:0] c);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_char_code <= c;
        do @(posedge i_clk); while (o_stall);
        tokenize_item(fn, c);
        n_fed++;
    endtask

    task automatic feed(input logic fn, input logic [7:0] c);
        drive_item(fn, c);
        file_tokens();
    endtask

    task automatic feed_non_quote();
        logic [7:0] c;
        c = 8'($urandom_range(254));
        if (c >= 8'h22) c = c + 8'd1;
        feed(1'b0, c);
    endtask

    task automatic feed_phrase();
        int    r;
        int    n;
        string w;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 20) begin
            if ($urandom_range(1)) begin
                w = KEYWORDS[$urandom_range(5)];
                n = ($urandom_range(3) == 0) ? w.len() - 1 : w.len();
                for (int k = 0; k < n; k++) feed(1'b0, w[k]);
                if ($urandom_range(2) == 0) begin
                    repeat ($urandom_range(1, 3)) feed(1'b0, pick(WORD_CHARS));
                end
            end else begin
                feed(1'b0, pick(HEAD_CHARS));
                repeat ($urandom_range(0, 9)) feed(1'b0, pick(WORD_CHARS));
            end
        end else if (r < 35) begin
            repeat ($urandom_range(1, 6)) feed(1'b0, 8'("0") + 8'($urandom_range(9)));
        end else if (r < 50) begin
            feed(1'b0, "\"");
            repeat ($urandom_range(0, 8)) feed_non_quote();
            feed(1'b0, "\"");
        end else if (r < 65) begin
            feed(1'b0, pick(OP_CHARS));
            if ($urandom_range(1)) feed(1'b0, "=");
        end else if (r < 80) begin
            feed(1'b0, pick(PUNCT_CHARS));
        end else if (r < 88) begin
            repeat ($urandom_range(1, 3)) begin
                c = 8'($urandom_range(5));
                feed(1'b0, (c == 8'd5) ? 8'(" ") : 8'd9 + c);
            end
        end else if (r < 92) begin
            feed(1'b1, 8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 4)) feed(1'b0, pick(NOISE_CHARS));
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens still due", cycle_cnt,
                     tokens_due.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_due_tok w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (tokens_due.size() == 0) begin
                report_mismatch($sformatf("token kind %0d start %0h with nothing due",
                                          o_token_kind, o_token_start));
            end else begin
                w = tokens_due.pop_front();
                if (o_token_kind != w.tok.kind)
                    report_mismatch($sformatf("kind got %0d want %0d",
                                              o_token_kind, w.tok.kind));
                if (o_token_start != w.tok.start)
                    report_mismatch($sformatf("start got %0h want %0h",
                                              o_token_start, w.tok.start));
                if (o_token_length != w.tok.length)
                    report_mismatch($sformatf("length got %0h want %0h",
                                              o_token_length, w.tok.length));
                if (o_run_last != w.last)
                    report_mismatch($sformatf("run_last got %0b want %0b",
                                              o_run_last, w.last));
            end
        end
    end

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        int base;
        idle_tab = '{0, 55, 0, 37};
        stall_tab = '{0, 0, 55, 37};
        lx_mode = LX_IDLE;
        lx_pos = '0;
        lx_begin = '0;
        lx_count = '0;
        lx_kw = '0;
        lx_err = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 24; i++) begin
            drive_item(dir_plan[i].fn, dir_plan[i].ch);
            if (dir_plan[i].n_typed != 0) begin
                step_toks.delete();
                step_toks.insert(step_toks.size(), dir_plan[i].e0);
                if (dir_plan[i].n_typed == 2) step_toks.insert(step_toks.size(), dir_plan[i].e1);
            end
            file_tokens();
        end

        base = n_fed;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = idle_tab[ph];
            stall_pct = stall_tab[ph];
            while (n_fed - base < (RANDOM_ITEMS / 4) * (ph + 1)) feed_phrase();
            if (ph == 1) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (tokens_due.size() != 0);
            end
        end

        // The error flag is sticky until reset, so it is raised only at the end.
        idle_pct = 37;
        stall_pct = 37;
        if ($urandom_range(1)) begin
            feed(1'b0, "\"");
            repeat ($urandom_range(0, 5)) feed_non_quote();
            feed(1'b1, 8'($urandom_range(255)));
        end else begin
            feed(1'b0, "x");
            feed(1'b0, "9");
            case ($urandom_range(2))
                0: feed(1'b0, 8'h00);
                1: feed(1'b0, 8'hFF);
                default: feed(1'b0, 8'($urandom_range(128, 255)));
            endcase
        end
        feed(1'b0, 8'h00);
        feed(1'b0, 8'hFF);
        repeat (20) feed($urandom_range(4) == 0, 8'($urandom_range(255)));
        feed(1'b1, 8'h00);

        i_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
